// ===== rtl/core/fis_pkg.sv =====
// ----------------------------------------------------------------------------
// fis_pkg
// Shared types, constants and helpers of the frame impairment scheduler.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_SENDS   = 16;
    localparam int SENDS_W     = $clog2(MAX_SENDS + 1);

    localparam logic [63:0] DEFAULT_SEED  = 64'h0000_00C0_FFEE_1234;
    localparam logic [63:0] DUP_OFFSET_NS = 64'd1_000_000;
    localparam logic [63:0] WAIT_CAP_NS   = 64'd150_000_000;

    localparam logic [2:0] CFG_LOSS_PROB    = 3'd0;
    localparam logic [2:0] CFG_DUP_PROB     = 3'd1;
    localparam logic [2:0] CFG_REORDER_PROB = 3'd2;
    localparam logic [2:0] CFG_DELAY_MEAN   = 3'd3;
    localparam logic [2:0] CFG_DELAY_JITTER = 3'd4;
    localparam logic [2:0] CFG_NS_PER_BYTE  = 3'd5;
    localparam logic [2:0] CFG_RNG_SEED     = 3'd6;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_LOSS   = 11'b000_0000_0010,
        ST_JIT    = 11'b000_0000_0100,
        ST_PUSH   = 11'b000_0000_1000,
        ST_DUP    = 11'b000_0001_0000,
        ST_SWAP   = 11'b000_0010_0000,
        ST_SWRA   = 11'b000_0100_0000,
        ST_SWRB   = 11'b000_1000_0000,
        ST_SWWB   = 11'b001_0000_0000,
        ST_HREQ   = 11'b010_0000_0000,
        ST_DRAIN  = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic [63:0] ready;
        logic [15:0] len;
        logic [15:0] tag;
    } t_entry;

    // One xorshift64 step (13, 7, 17).
    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    // Queue slot k places after head, wrapping at the queue depth.
    function automatic logic [HEAD_W-1:0] slot(input logic [HEAD_W-1:0] head,
                                               input logic [HEAD_W-1:0] k);
        logic [HEAD_W:0] s;
        s = {1'b0, head} + {1'b0, k};
        if (s >= (HEAD_W+1)'(QUEUE_DEPTH)) begin
            s = s - (HEAD_W+1)'(QUEUE_DEPTH);
        end
        return s[HEAD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/frame_impairment_scheduler.sv =====
// ----------------------------------------------------------------------------
// frame_impairment_scheduler
// Loss, jitter, duplicate and reorder impairment with token spacing drain.
// ----------------------------------------------------------------------------
// A frame is taken when start is high and busy is low. One xorshift64 unit
// makes each decision in turn, one draw a cycle, and one write port and one
// read port of the queue RAM handle pushes, the head-pair swap and the drain.
// A lost frame ends after the loss draw. Any other frame goes through the
// jitter draw, the push, the duplicate draw, the swap draw when two or more
// entries are queued, the head-pair swap when it is taken, the head request
// and the drain. Results leave one per cycle on o_valid and cannot be
// held off; the last one carries o_is_last and busy falls with it.
module frame_impairment_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_frame_tag,
    input  logic [15:0] i_frame_len,
    input  logic [62:0] i_now_ns,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_sent_valid,
    output logic [15:0] o_out_tag,
    output logic [15:0] o_out_len,
    output logic        o_is_last,
    output logic [19:0] o_returned_bytes,
    output logic        o_was_dropped,
    output logic        o_queue_overflow
);

    localparam int HW = fis_pkg::HEAD_W;
    localparam int CW = fis_pkg::COUNT_W;
    localparam int SW = fis_pkg::SENDS_W;

    fis_pkg::t_state r_state, n_state;

    logic [16:0] r_loss_prob, r_dup_prob, r_reorder_prob;
    logic [31:0] r_delay_mean, r_delay_jitter;
    logic [15:0] r_ns_per_byte;
    logic [63:0] r_rng, n_rng;
    logic [63:0] r_next_send, n_next_send;
    logic [HW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    logic [15:0] r_tag, r_len;
    logic [62:0] r_now;
    logic [63:0] r_prod, n_prod;
    logic [63:0] r_ready, n_ready;
    logic [63:0] r_t, n_t;
    logic        r_ovf, n_ovf;
    logic [SW-1:0] r_nsent, n_nsent;
    logic [19:0] r_bytes, n_bytes;
    fis_pkg::t_entry r_ent_a, n_ent_a;

    logic        r_pend, n_pend;
    logic [15:0] r_pend_tag, n_pend_tag, r_pend_len, n_pend_len;
    logic [19:0] r_pend_bytes, n_pend_bytes;

    logic        r_o_valid, n_o_valid, r_o_sent, n_o_sent, r_o_last, n_o_last;
    logic        r_o_drop, n_o_drop, r_o_ovf, n_o_ovf;
    logic [15:0] r_o_tag, n_o_tag, r_o_len, n_o_len;
    logic [19:0] r_o_bytes, n_o_bytes;

    fis_pkg::t_entry r_mem [fis_pkg::QUEUE_DEPTH];
    fis_pkg::t_entry r_rd_data;
    logic [HW-1:0]   rd_addr, wr_addr;
    logic            wr_en;
    fis_pkg::t_entry wr_data;

    logic [63:0] draw;
    logic        accept;
    logic [33:0] jsum, jdelay;
    logic [63:0] rem, cap_t;
    logic [31:0] byte_time;
    logic        release_ok;

    assign accept = start && (r_state == fis_pkg::ST_IDLE);
    assign busy = (r_state != fis_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign draw = fis_pkg::xorshift(r_rng);

    assign jsum = {2'b00, r_delay_mean} + {1'b0, r_prod[63:31]};
    assign jdelay = (jsum < {2'b00, r_delay_jitter}) ? 34'd0
                                                     : jsum - {2'b00, r_delay_jitter};
    assign rem = r_rd_data.ready - {1'b0, r_now};
    assign cap_t = {1'b0, r_now} + ((rem > fis_pkg::WAIT_CAP_NS) ? fis_pkg::WAIT_CAP_NS : rem);
    assign byte_time = {16'h0, r_ns_per_byte} * {16'h0, r_rd_data.len};

    assign release_ok = (r_count != '0) && (r_nsent < SW'(fis_pkg::MAX_SENDS))
                        && (r_rd_data.ready <= r_t)
                        && ((r_ns_per_byte == '0) || (r_t >= r_next_send));

    always_comb begin
        n_state = r_state;
        n_rng = r_rng;
        n_next_send = r_next_send;
        n_head = r_head;
        n_count = r_count;
        n_prod = r_prod;
        n_ready = r_ready;
        n_t = r_t;
        n_ovf = r_ovf;
        n_nsent = r_nsent;
        n_bytes = r_bytes;
        n_ent_a = r_ent_a;
        n_pend = r_pend;
        n_pend_tag = r_pend_tag;
        n_pend_len = r_pend_len;
        n_pend_bytes = r_pend_bytes;
        n_o_valid = 1'b0;
        n_o_sent = 1'b0;
        n_o_last = 1'b0;
        n_o_drop = 1'b0;
        n_o_ovf = 1'b0;
        n_o_tag = '0;
        n_o_len = '0;
        n_o_bytes = '0;
        rd_addr = r_head;
        wr_en = 1'b0;
        wr_addr = fis_pkg::slot(r_head, r_count[HW-1:0]);
        wr_data = '{ready: r_ready, len: r_len, tag: r_tag};

        unique case (r_state)
            fis_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = fis_pkg::ST_LOSS;
                end
            end
            fis_pkg::ST_LOSS: begin
                n_rng = draw;
                n_ovf = 1'b0;
                n_nsent = '0;
                n_bytes = '0;
                n_pend = 1'b0;
                if ({1'b0, draw[63:48]} < r_loss_prob) begin
                    n_o_valid = 1'b1;
                    n_o_last = 1'b1;
                    n_o_drop = 1'b1;
                    n_o_bytes = {4'h0, r_len};
                    n_state = fis_pkg::ST_IDLE;
                end else begin
                    n_state = fis_pkg::ST_JIT;
                end
            end
            fis_pkg::ST_JIT: begin
                n_rng = draw;
                n_prod = {32'h0, draw[63:32]} * {32'h0, r_delay_jitter};
                n_state = fis_pkg::ST_PUSH;
            end
            fis_pkg::ST_PUSH: begin
                n_ready = {1'b0, r_now} + {30'h0, jdelay};
                wr_data.ready = n_ready;
                if (r_count < CW'(fis_pkg::QUEUE_DEPTH)) begin
                    wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = fis_pkg::ST_DUP;
            end
            fis_pkg::ST_DUP: begin
                n_rng = draw;
                wr_data.ready = r_ready + fis_pkg::DUP_OFFSET_NS;
                if ({1'b0, draw[63:48]} < r_dup_prob) begin
                    if (r_count < CW'(fis_pkg::QUEUE_DEPTH)) begin
                        wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = (n_count >= CW'(2)) ? fis_pkg::ST_SWAP : fis_pkg::ST_HREQ;
            end
            fis_pkg::ST_SWAP: begin
                n_rng = draw;
                n_state = ({1'b0, draw[63:48]} < r_reorder_prob) ? fis_pkg::ST_SWRA
                                                                 : fis_pkg::ST_HREQ;
            end
            fis_pkg::ST_SWRA: begin
                // hold entry a, fetch entry b
                n_ent_a = r_rd_data;
                rd_addr = fis_pkg::slot(r_head, HW'(1));
                n_state = fis_pkg::ST_SWRB;
            end
            fis_pkg::ST_SWRB: begin
                wr_en = 1'b1;
                wr_addr = r_head;
                wr_data = r_rd_data;
                n_state = fis_pkg::ST_SWWB;
            end
            fis_pkg::ST_SWWB: begin
                wr_en = 1'b1;
                wr_addr = fis_pkg::slot(r_head, HW'(1));
                wr_data = r_ent_a;
                n_state = fis_pkg::ST_HREQ;
            end
            fis_pkg::ST_HREQ: begin
                n_t = {1'b0, r_now};
                n_state = fis_pkg::ST_DRAIN;
            end
            fis_pkg::ST_DRAIN: begin
                // first drain cycle: set drain time from the head entry
                if (r_nsent == '0 && !r_pend && r_count != '0
                        && r_rd_data.ready > {1'b0, r_now} && r_t == {1'b0, r_now}) begin
                    n_t = cap_t;
                end else if (release_ok) begin
                    if (r_ns_per_byte != '0) begin
                        n_next_send = r_t + {32'h0, byte_time};
                    end
                    n_bytes = r_bytes + {4'h0, r_rd_data.len};
                    if (r_pend) begin
                        n_o_valid = 1'b1;
                        n_o_sent = 1'b1;
                        n_o_tag = r_pend_tag;
                        n_o_len = r_pend_len;
                        n_o_bytes = r_pend_bytes;
                        n_o_ovf = r_ovf;
                    end
                    n_pend = 1'b1;
                    n_pend_tag = r_rd_data.tag;
                    n_pend_len = r_rd_data.len;
                    n_pend_bytes = n_bytes;
                    n_head = fis_pkg::slot(r_head, HW'(1));
                    n_count = r_count - 1'b1;
                    n_nsent = r_nsent + 1'b1;
                    rd_addr = n_head;
                end else begin
                    n_o_valid = 1'b1;
                    n_o_last = 1'b1;
                    n_o_ovf = r_ovf;
                    if (r_pend) begin
                        n_o_sent = 1'b1;
                        n_o_tag = r_pend_tag;
                        n_o_len = r_pend_len;
                        n_o_bytes = r_pend_bytes;
                    end else begin
                        n_o_bytes = {4'h0, r_len};
                    end
                    n_pend = 1'b0;
                    n_state = fis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fis_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fis_pkg::ST_IDLE;
            r_loss_prob <= '0;
            r_dup_prob <= '0;
            r_reorder_prob <= '0;
            r_delay_mean <= '0;
            r_delay_jitter <= '0;
            r_ns_per_byte <= '0;
            r_rng <= fis_pkg::DEFAULT_SEED;
            r_next_send <= '0;
            r_head <= '0;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_nsent <= '0;
            r_bytes <= '0;
            r_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rng <= n_rng;
            r_next_send <= n_next_send;
            r_head <= n_head;
            r_count <= n_count;
            r_ovf <= n_ovf;
            r_nsent <= n_nsent;
            r_bytes <= n_bytes;
            r_pend <= n_pend;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fis_pkg::CFG_LOSS_PROB:    r_loss_prob <= i_cfg_data[16:0];
                    fis_pkg::CFG_DUP_PROB:     r_dup_prob <= i_cfg_data[16:0];
                    fis_pkg::CFG_REORDER_PROB: r_reorder_prob <= i_cfg_data[16:0];
                    fis_pkg::CFG_DELAY_MEAN:   r_delay_mean <= i_cfg_data[31:0];
                    fis_pkg::CFG_DELAY_JITTER: r_delay_jitter <= i_cfg_data[31:0];
                    fis_pkg::CFG_NS_PER_BYTE:  r_ns_per_byte <= i_cfg_data[15:0];
                    fis_pkg::CFG_RNG_SEED: begin
                        r_rng <= (i_cfg_data == '0) ? fis_pkg::DEFAULT_SEED : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag <= i_frame_tag;
            r_len <= i_frame_len;
            r_now <= i_now_ns;
        end
        r_prod <= n_prod;
        r_ready <= n_ready;
        r_t <= n_t;
        r_ent_a <= n_ent_a;
        r_pend_tag <= n_pend_tag;
        r_pend_len <= n_pend_len;
        r_pend_bytes <= n_pend_bytes;
        r_o_sent <= n_o_sent;
        r_o_last <= n_o_last;
        r_o_drop <= n_o_drop;
        r_o_ovf <= n_o_ovf;
        r_o_tag <= n_o_tag;
        r_o_len <= n_o_len;
        r_o_bytes <= n_o_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid = r_o_valid;
    assign o_sent_valid = r_o_sent;
    assign o_out_tag = r_o_tag;
    assign o_out_len = r_o_len;
    assign o_is_last = r_o_last;
    assign o_returned_bytes = r_o_bytes;
    assign o_was_dropped = r_o_drop;
    assign o_queue_overflow = r_o_ovf;

endmodule

// ===== rtl/core/fis_checker.sv =====
// ----------------------------------------------------------------------------
// fis_port_checks
// Port-level checks of the frame impairment scheduler result stream.
// ----------------------------------------------------------------------------
module fis_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_sent_valid,
    input logic        o_is_last,
    input logic        o_was_dropped
);

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_dropped |-> o_is_last && !o_sent_valid)
        else $error("dropped result not a lone status");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sent_valid |-> o_is_last)
        else $error("status result not last");

    // released frames of one transaction come back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |=> o_valid)
        else $error("gap inside result burst");

endmodule

bind frame_impairment_scheduler fis_port_checks u_fis_port_checks (.*);
